/* design/fsp_pkg.sv */
// Shared types, bit positions and constants for the format spec parser.
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

	typedef enum logic [1:0] {
		PH_FLAGS = 2'd0,
		PH_WIDTH = 2'd1,
		PH_PREC  = 2'd2,
		PH_DONE  = 2'd3
	} fsp_phase_t;

	// Flag bit positions
	localparam int FB_LEFT  = 0;
	localparam int FB_ZERO  = 1;
	localparam int FB_PLUS  = 2;
	localparam int FB_SPACE = 3;
	localparam int FB_COMMA = 4;
	localparam int FLAG_W   = 5;

	// Modifier bit positions
	localparam int MB_UPPER = 0;
	localparam int MB_WORD  = 1;
	localparam int MB_YN    = 2;
	localparam int MOD_W    = 3;

	localparam int NUM_W = 16;

	localparam logic signed [NUM_W-1:0] NUM_NONE = -16'sd1;
	localparam logic signed [NUM_W-1:0] SAT_MAX  = 16'sh7FFF;

	typedef struct packed {
		fsp_phase_t              phase;
		logic [FLAG_W-1:0]       flags;
		logic signed [NUM_W-1:0] width_acc;
		logic signed [NUM_W-1:0] prec_acc;
		logic [7:0]              type_code;
		logic [MOD_W-1:0]        mods;
	} fsp_state_t;

	localparam fsp_state_t ST_RESET = '{
		phase:     PH_FLAGS,
		flags:     '0,
		width_acc: NUM_NONE,
		prec_acc:  NUM_NONE,
		type_code: 8'h00,
		mods:      '0
	};

endpackage

`default_nettype wire

/* design/fsp_decode.sv */
// Per-character next-state decode of the format spec parser.
`timescale 1ns / 1ps
`default_nettype none

module fsp_decode
	import fsp_pkg::*;
(
	input  wire fsp_state_t cur,
	input  wire logic [7:0] char_code,
	input  wire logic       has_char,
	output fsp_state_t      nxt
);

	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_SPACE = " ";
	localparam logic [7:0] CH_COMMA = ",";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_UX    = "X";
	localparam logic [7:0] CH_UE    = "E";
	localparam logic [7:0] CH_UG    = "G";
	localparam logic [7:0] CH_UP    = "P";
	localparam logic [7:0] CH_UB    = "B";
	localparam logic [7:0] CH_UT    = "T";
	localparam logic [7:0] CH_UY    = "Y";
	localparam logic [7:0] CH_UQ    = "Q";
	localparam logic [7:0] CH_LX    = "x";
	localparam logic [7:0] CH_LE    = "e";
	localparam logic [7:0] CH_LG    = "g";
	localparam logic [7:0] CH_LP    = "p";
	localparam logic [7:0] CH_LB    = "b";
	localparam logic [7:0] CH_LT    = "t";
	localparam logic [7:0] CH_LY    = "y";
	localparam logic [7:0] CH_LQ    = "q";

	// acc * 10 + digit, saturated; a negative acc counts as zero
	function automatic logic signed [NUM_W-1:0] push_digit(
		input logic signed [NUM_W-1:0] acc,
		input logic [7:0]              c
	);
		logic [NUM_W-2:0] base;
		logic [NUM_W+3:0] sum;
		base = acc[NUM_W-1] ? '0 : acc[NUM_W-2:0];
		sum  = {2'b00, base, 3'b000} + {4'b0000, base, 1'b0} + {16'h0000, c[3:0]};
		if (sum > {4'b0000, SAT_MAX}) begin
			return SAT_MAX;
		end
		return {1'b0, sum[NUM_W-2:0]};
	endfunction

	logic             is_dig;
	logic             is_dot;
	logic             is_flag;
	logic [7:0]       typ;
	logic [MOD_W-1:0] mod;
	fsp_phase_t       phase_nxt;

	assign is_dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_dot = (char_code == CH_DOT);
	assign is_flag = (char_code == CH_MINUS) || (char_code == CH_ZERO) ||
		(char_code == CH_PLUS) || (char_code == CH_SPACE) || (char_code == CH_COMMA);

	// Type letter decode
	always_comb begin
		typ = char_code;
		mod = '0;
		unique case (char_code)
			CH_UX: begin typ = CH_LX; mod[MB_UPPER] = 1'b1; end
			CH_UE: begin typ = CH_LE; mod[MB_UPPER] = 1'b1; end
			CH_UG: begin typ = CH_LG; mod[MB_UPPER] = 1'b1; end
			CH_UP: begin typ = CH_LP; mod[MB_UPPER] = 1'b1; end
			CH_UB: begin
				typ = CH_LB;
				mod[MB_UPPER] = 1'b1;
				mod[MB_WORD] = 1'b1;
			end
			CH_UT: begin typ = CH_LB; mod[MB_UPPER] = 1'b1; end
			CH_UY: begin
				typ = CH_LB;
				mod[MB_UPPER] = 1'b1;
				mod[MB_YN] = 1'b1;
			end
			CH_UQ: begin
				typ = CH_LB;
				mod = '1;
			end
			CH_LB: begin typ = CH_LB; mod[MB_WORD] = 1'b1; end
			CH_LT: begin typ = CH_LB; end
			CH_LY: begin typ = CH_LB; mod[MB_YN] = 1'b1; end
			CH_LQ: begin
				typ = CH_LB;
				mod[MB_YN] = 1'b1;
				mod[MB_WORD] = 1'b1;
			end
			default: begin end
		endcase
	end

	// Next phase
	always_comb begin
		phase_nxt = cur.phase;
		if (has_char) begin
			unique case (cur.phase)
				PH_FLAGS: begin
					priority if (is_flag) phase_nxt = PH_FLAGS;
					else if (is_dig) phase_nxt = PH_WIDTH;
					else if (is_dot) phase_nxt = PH_PREC;
					else phase_nxt = PH_DONE;
				end
				PH_WIDTH: begin
					priority if (is_dig) phase_nxt = PH_WIDTH;
					else if (is_dot) phase_nxt = PH_PREC;
					else phase_nxt = PH_DONE;
				end
				PH_PREC: begin
					if (!is_dig) phase_nxt = PH_DONE;
				end
				PH_DONE: begin end
				default: begin end
			endcase
		end
	end

	// Field updates
	always_comb begin
		nxt.phase     = phase_nxt;
		nxt.flags     = cur.flags;
		nxt.width_acc = cur.width_acc;
		nxt.prec_acc  = cur.prec_acc;
		nxt.type_code = cur.type_code;
		nxt.mods      = cur.mods;
		if (has_char) begin
			unique case (cur.phase)
				PH_FLAGS: begin
					priority if (char_code == CH_MINUS) nxt.flags[FB_LEFT] = 1'b1;
					else if (char_code == CH_ZERO) nxt.flags[FB_ZERO] = 1'b1;
					else if (char_code == CH_PLUS) nxt.flags[FB_PLUS] = 1'b1;
					else if (char_code == CH_SPACE) nxt.flags[FB_SPACE] = 1'b1;
					else if (char_code == CH_COMMA) nxt.flags[FB_COMMA] = 1'b1;
					else if (is_dig) nxt.width_acc = push_digit(NUM_NONE, char_code);
					else if (is_dot) nxt.prec_acc = '0;
					else begin
						nxt.type_code = typ;
						nxt.mods = mod;
					end
				end
				PH_WIDTH: begin
					priority if (is_dig) nxt.width_acc = push_digit(cur.width_acc, char_code);
					else if (is_dot) nxt.prec_acc = '0;
					else begin
						nxt.type_code = typ;
						nxt.mods = mod;
					end
				end
				PH_PREC: begin
					if (is_dig) begin
						nxt.prec_acc = push_digit(cur.prec_acc, char_code);
					end else begin
						nxt.type_code = typ;
						nxt.mods = mod;
					end
				end
				PH_DONE: begin end
				default: begin end
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/format_spec_parser_unit.sv */
// Top level of the format spec parser: input stage, parse state, result register.
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall   | char_code, has_char, last
//  out     | source    | out_valid / out_stall | flags, field_width, digits_after, type
//
//  One beat per cycle in while in_stall is low: a character goes from the input register
//  through one decode step into the parse state on the next edge.
//  A beat marked last finishes the spec; its result is decoded from the input register
//  into the output register, and the parse state resets.
//  Reset clears the input/output valid bits and the parse state.
//  in_stall rises only when a last beat waits in the input register while
//  the output register still holds an untaken result.

module format_spec_parser_unit
	import fsp_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,

	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [7:0]              char_code,
	input  wire logic                    has_char,
	input  wire logic                    last,

	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         flag_left,
	output logic                         flag_zero,
	output logic                         flag_plus,
	output logic                         flag_space,
	output logic                         thousands,
	output logic signed [NUM_W-1:0]      field_width,
	output logic signed [NUM_W-1:0]      digits_after,
	output logic [7:0]                   type_code,
	output logic                         uppercase,
	output logic                         word_form,
	output logic                         yes_no
);

	// Input stage
	logic       s1_valid_s1;
	logic [7:0] s1_char_s1;
	logic       s1_has_s1;
	logic       s1_last_s1;

	// Parse state and result register
	fsp_state_t st_q;
	fsp_state_t st_nxt;
	fsp_state_t res_q;
	logic       out_valid_q;

	logic s1_go;
	logic res_load;
	logic in_take;

	// A non-last beat always advances; a last beat needs a free result slot
	assign s1_go    = s1_valid_s1 && (!s1_last_s1 || !out_valid_q || !out_stall);
	assign res_load = s1_go && s1_last_s1;
	assign in_stall = s1_valid_s1 && !s1_go;
	assign in_take  = in_valid && !in_stall;

	fsp_decode u_decode (
		.cur       (st_q),
		.char_code (s1_char_s1),
		.has_char  (s1_has_s1),
		.nxt       (st_nxt)
	);

	// Hold the input beat until it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_take) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_go) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			s1_char_s1 <= char_code;
			s1_has_s1  <= has_char;
			s1_last_s1 <= last;
		end
	end

	// Advance parse state; drop back to defaults after a finished spec
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (s1_go) begin
			st_q <= s1_last_s1 ? ST_RESET : st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= st_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign flag_left    = res_q.flags[FB_LEFT];
	assign flag_zero    = res_q.flags[FB_ZERO];
	assign flag_plus    = res_q.flags[FB_PLUS];
	assign flag_space   = res_q.flags[FB_SPACE];
	assign thousands    = res_q.flags[FB_COMMA];
	assign field_width  = res_q.width_acc;
	assign digits_after = res_q.prec_acc;
	assign type_code    = res_q.type_code;
	assign uppercase    = res_q.mods[MB_UPPER];
	assign word_form    = res_q.mods[MB_WORD];
	assign yes_no       = res_q.mods[MB_YN];

	// Stall only for a last beat blocked by an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_s1 && s1_last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// Parse state restarts after every result
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (st_q.phase == PH_FLAGS && st_q.flags == '0 &&
			st_q.width_acc == NUM_NONE && st_q.prec_acc == NUM_NONE))
		else $error("parse state not cleared after result");

	// Accumulators are either absent or non-negative
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.width_acc[NUM_W-1] |-> (st_q.width_acc == NUM_NONE))
		else $error("width accumulator out of range");

	a_prec_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.prec_acc[NUM_W-1] |-> (st_q.prec_acc == NUM_NONE))
		else $error("precision accumulator out of range");

	// A taken result with nothing behind it frees the output
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !res_load) |=> !out_valid_q)
		else $error("result repeated");

endmodule

`default_nettype wire
